/* rtl/core/twcc_pkg.sv */
// shared types and constants for the arrival window recorder
// no dependencies; imported by every module in rtl/core
package twcc_pkg;

    localparam int WINDOW_SPAN_DEF = 64;

    localparam int TIME_W    = 48;
    localparam int SEQ_W     = 16;
    localparam int DIFF_W    = TIME_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_SSRC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIA_SSRC  = 3'd4;

    // register reset values
    localparam logic [31:0] WINDOW_TIME_RST = 32'd100000;
    localparam logic [6:0]  BACKLOG_RST     = 7'd64;
    localparam logic [30:0] EPOCH_LIMIT_RST = 31'd240000000;

    // result kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_RECEIVED = 2'd1;
    localparam logic [1:0] KIND_LOST     = 2'd2;

    // operations
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_BUILD   = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } t_store_ctrl;

endpackage

/* rtl/core/twcc_slot_store.sv */
// arrival time memory with per-slot present bits
// depends on twcc_pkg for the control struct and time width
module twcc_slot_store #(
    parameter int WINDOW_SPAN = twcc_pkg::WINDOW_SPAN_DEF,
    parameter int AW = $clog2(WINDOW_SPAN)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  twcc_pkg::t_store_ctrl      i_ctrl,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [twcc_pkg::TIME_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [twcc_pkg::TIME_W-1:0] o_rd_data,
    output logic [WINDOW_SPAN-1:0]     o_present
);
    import twcc_pkg::*;

    logic [TIME_W-1:0]      r_mem [WINDOW_SPAN];
    logic [TIME_W-1:0]      r_rd_data;
    logic [WINDOW_SPAN-1:0] r_present;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // present bits: set on write, wiped when a build finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_ctrl.clr) begin
            r_present <= '0;
        end else if (i_ctrl.wr_en) begin
            r_present[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_present = r_present;

endmodule

/* rtl/core/twcc_sub_unit.sv */
// shared time subtractor with registered signed result
// depends on twcc_pkg for time and difference widths
module twcc_sub_unit (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [twcc_pkg::TIME_W-1:0]        i_a,
    input  logic [twcc_pkg::TIME_W-1:0]        i_b,
    output logic signed [twcc_pkg::DIFF_W-1:0] o_diff
);
    import twcc_pkg::*;

    logic signed [DIFF_W-1:0] r_diff;

    // exact 48-bit difference, one extra bit for the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= $signed({1'b0, i_a}) - $signed({1'b0, i_b});
        end
    end

    assign o_diff = r_diff;

endmodule

/* rtl/core/twcc_arrival_window_recorder_unit.sv */
// top level of the arrival window recorder: sequencer, registers, result port
// depends on twcc_pkg, twcc_slot_store and twcc_sub_unit
//
// Records packet arrival times by transport sequence number into a window of
// WINDOW_SPAN slots and, on a build request, emits one feedback transaction per
// slot from offset zero up to the highest offset seen. An arrival transaction
// is taken without raising busy. A build that is not ready (empty window, or
// too young with too few packets) holds busy only in the decide state and
// then gives a single no-feedback result with o_last set. A ready build holds
// busy while the single shared subtractor forms the window age, then the
// first arrival against the epoch, then while each slot in turn goes through
// a memory read, a subtract and an output step.
// Results appear on the output ports for exactly one cycle, marked by o_valid,
// and the receiver cannot stall them; the next start is taken once busy drops.
// Configuration may be written only while busy is low.
module twcc_arrival_window_recorder_unit #(
    parameter int WINDOW_SPAN = twcc_pkg::WINDOW_SPAN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [twcc_pkg::SEQ_W-1:0]          i_seq,
    input  logic [twcc_pkg::TIME_W-1:0]         i_time_us,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [twcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [twcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // result channel
    output logic                                o_valid,
    output logic [1:0]                          o_kind,
    output logic [twcc_pkg::SEQ_W-1:0]          o_packet_seq,
    output logic [twcc_pkg::SEQ_W-1:0]          o_base_seq,
    output logic [30:0]                         o_ref_time_us,
    output logic signed [31:0]                  o_rel_arrival_us,
    output logic [31:0]                         o_out_sender_ssrc,
    output logic [31:0]                         o_out_media_ssrc,
    output logic                                o_last
);
    import twcc_pkg::*;

    localparam int AW = $clog2(WINDOW_SPAN);
    localparam int CW = AW + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECIDE    = 3'd1;  // age known, ready check
    localparam logic [2:0] S_EPOCH     = 3'd2;  // first arrival minus epoch
    localparam logic [2:0] S_EPOCH_CHK = 3'd3;  // epoch reset, reference time
    localparam logic [2:0] S_READ      = 3'd4;  // read slot arrival
    localparam logic [2:0] S_SUB       = 3'd5;  // slot arrival minus epoch
    localparam logic [2:0] S_EMIT      = 3'd6;  // drive one result

    // configuration registers
    logic [31:0] r_wtime;
    logic [6:0]  r_backlog;
    logic [30:0] r_elimit;
    logic [31:0] r_sender;
    logic [31:0] r_media;

    // window and epoch state
    logic [2:0]        r_state;
    logic              r_epoch_valid;
    logic [TIME_W-1:0] r_epoch;
    logic [SEQ_W-1:0]  r_wbase;
    logic [TIME_W-1:0] r_wstart;
    logic [CW-1:0]     r_pending;
    logic [AW-1:0]     r_hi;
    logic [AW-1:0]     r_off;
    logic [TIME_W-1:0] r_first;
    logic [30:0]       r_ref;

    // result registers
    logic              r_valid;
    logic [1:0]        r_kind;
    logic [SEQ_W-1:0]  r_pseq;
    logic [SEQ_W-1:0]  r_bseq;
    logic [30:0]       r_oref;
    logic [31:0]       r_rel;
    logic [31:0]       r_osender;
    logic [31:0]       r_omedia;
    logic              r_last;

    // store and subtractor hookup
    t_store_ctrl              w_sctrl;
    logic [AW-1:0]            w_rd_addr;
    logic [TIME_W-1:0]        w_rd_data;
    logic [WINDOW_SPAN-1:0]   w_present;
    logic                     w_sub_en;
    logic [TIME_W-1:0]        w_sub_a;
    logic [TIME_W-1:0]        w_sub_b;
    logic signed [DIFF_W-1:0] w_diff;

    // arrival offset decode
    logic             w_accept;
    logic             w_arrival;
    logic             w_build;
    logic [SEQ_W-1:0] w_base_eff;
    logic [SEQ_W-1:0] w_off16;
    logic             w_in_span;
    logic [AW-1:0]    w_off;
    logic             w_too_young;
    logic             w_few;
    logic             w_not_ready;
    logic             w_epoch_old;
    logic [31:0]      w_rel_sat;
    logic             w_slot_last;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_arrival = w_accept && (i_operation == OP_ARRIVAL);
    assign w_build   = w_accept && (i_operation == OP_BUILD);

    // an empty window is reopened at this packet's sequence number
    assign w_base_eff = (r_pending == '0) ? i_seq : r_wbase;
    assign w_off16    = i_seq - w_base_eff;
    assign w_in_span  = (w_off16 < SEQ_W'(WINDOW_SPAN));
    assign w_off      = w_off16[AW-1:0];

    // ready check on the age held in the subtractor
    assign w_too_young = (w_diff < $signed({{(DIFF_W-32){1'b0}}, r_wtime}));
    assign w_few       = (7'(r_pending) < r_backlog);
    assign w_not_ready = (r_pending == '0) || (w_too_young && w_few);
    assign w_epoch_old = (w_diff > $signed({{(DIFF_W-31){1'b0}}, r_elimit}));
    assign w_slot_last = (r_off == r_hi);

    // saturate the signed difference to 32 bits
    always_comb begin
        if (w_diff > $signed(DIFF_W'(32'h7FFF_FFFF))) begin
            w_rel_sat = 32'h7FFF_FFFF;
        end else if (w_diff < -$signed(DIFF_W'(33'h0_8000_0000))) begin
            w_rel_sat = 32'h8000_0000;
        end else begin
            w_rel_sat = w_diff[31:0];
        end
    end

    // store control and subtractor operand selection
    always_comb begin
        w_sctrl   = '0;
        w_rd_addr = '0;
        w_sub_en  = 1'b0;
        w_sub_a   = r_first;
        w_sub_b   = r_epoch;
        case (r_state)
            S_IDLE: begin
                w_sctrl.wr_en = w_arrival && w_in_span;
                w_sctrl.rd_en = w_build;          // slot zero for the epoch check
                w_sub_en      = w_build;
                w_sub_a       = i_time_us;
                w_sub_b       = r_wstart;
            end
            S_EPOCH: begin
                w_sub_en = 1'b1;
                w_sub_a  = w_rd_data;
            end
            S_READ: begin
                w_sctrl.rd_en = 1'b1;
                w_rd_addr     = r_off;
            end
            S_SUB: begin
                w_sub_en = 1'b1;
                w_sub_a  = w_rd_data;
            end
            S_EMIT: begin
                w_sctrl.clr = w_slot_last;
            end
            default: begin
                w_sctrl = '0;
            end
        endcase
    end

    twcc_slot_store #(
        .WINDOW_SPAN (WINDOW_SPAN),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_sctrl),
        .i_wr_addr (w_off),
        .i_wr_data (i_time_us),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_present (w_present)
    );

    twcc_sub_unit u_sub (
        .i_clk  (i_clk),
        .i_en   (w_sub_en),
        .i_a    (w_sub_a),
        .i_b    (w_sub_b),
        .o_diff (w_diff)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtime   <= WINDOW_TIME_RST;
            r_backlog <= BACKLOG_RST;
            r_elimit  <= EPOCH_LIMIT_RST;
            r_sender  <= '0;
            r_media   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_TIME: r_wtime   <= i_cfg_data;
                CFG_BACKLOG:     r_backlog <= i_cfg_data[6:0];
                CFG_EPOCH_LIMIT: r_elimit  <= i_cfg_data[30:0];
                CFG_SENDER_SSRC: r_sender  <= i_cfg_data;
                CFG_MEDIA_SSRC:  r_media   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_epoch_valid <= 1'b0;
            r_epoch       <= '0;
            r_wbase       <= '0;
            r_wstart      <= '0;
            r_pending     <= '0;
            r_hi          <= '0;
            r_off         <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_arrival) begin
                        if (!r_epoch_valid) begin
                            r_epoch       <= i_time_us;
                            r_epoch_valid <= 1'b1;
                        end
                        if (r_pending == '0) begin
                            r_wbase  <= i_seq;
                            r_wstart <= i_time_us;
                        end
                        // duplicates only overwrite the stored time
                        if (w_in_span && !w_present[w_off]) begin
                            r_pending <= r_pending + 1'b1;
                            if ((w_off > r_hi) || (r_pending == '0)) begin
                                r_hi <= w_off;
                            end
                        end
                    end else if (w_build) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_not_ready) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EPOCH;
                    end
                end
                S_EPOCH: begin
                    r_first <= w_rd_data;
                    r_state <= S_EPOCH_CHK;
                end
                S_EPOCH_CHK: begin
                    // an old epoch moves to the first arrival, so the reference is zero
                    if (w_epoch_old) begin
                        r_epoch <= r_first;
                        r_ref   <= '0;
                    end else if (w_diff < 0) begin
                        r_ref <= '0;
                    end else begin
                        r_ref <= w_diff[30:0];
                    end
                    r_off   <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    if (w_slot_last) begin
                        r_pending <= '0;
                        r_hi      <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_off   <= r_off + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_kind    <= KIND_NONE;
            r_pseq    <= '0;
            r_bseq    <= '0;
            r_oref    <= '0;
            r_rel     <= '0;
            r_osender <= '0;
            r_omedia  <= '0;
            r_last    <= 1'b1;
        end else if (r_state == S_EMIT) begin
            r_pseq    <= r_wbase + SEQ_W'(r_off);
            r_bseq    <= r_wbase;
            r_oref    <= r_ref;
            r_osender <= r_sender;
            r_omedia  <= r_media;
            r_last    <= w_slot_last;
            if (w_present[r_off]) begin
                r_kind <= KIND_RECEIVED;
                r_rel  <= w_rel_sat;
            end else begin
                r_kind <= KIND_LOST;
                r_rel  <= '0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_packet_seq      = r_pseq;
    assign o_base_seq        = r_bseq;
    assign o_ref_time_us     = r_oref;
    assign o_rel_arrival_us  = $signed(r_rel);
    assign o_out_sender_ssrc = r_osender;
    assign o_out_media_ssrc  = r_omedia;
    assign o_last            = r_last;

    // the count of distinct packets always equals the present bits set
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_present) == int'(r_pending))
        else $error("pending count out of step with present bits");

    // a non-empty window always holds its opening packet in slot zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) |-> w_present[0])
        else $error("window open without slot zero");

    // the final slot of a build leaves the window empty
    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_slot_last) |=> (r_pending == '0 && w_present == '0))
        else $error("window not cleared after build");

    // a no-feedback or lost result carries no arrival time
    a_no_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_NONE || o_kind == KIND_LOST)) |-> (o_rel_arrival_us == 0))
        else $error("arrival time on a result without one");

    // a no-feedback result is always the only one of its build
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_NONE) |-> o_last)
        else $error("no-feedback result not marked last");

endmodule

/* test/tb.sv */
// self-checking testbench for twcc_arrival_window_recorder_unit
// depends on twcc_pkg; predicts every feedback transaction and checks it on the fly
// directed window cases first, then random arrival/build traffic over six register setups
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twcc_pkg::*;

    localparam int SPAN          = WINDOW_SPAN_DEF;
    localparam int GAP_MAX       = 40;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 60;
    localparam int PRINT_MAX     = 40;
    // index past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // one feedback transaction as seen on the result ports
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] packet_seq;
        logic [15:0] base_seq;
        logic [30:0] ref_time;
        logic [31:0] rel_arrival;
        logic [31:0] sender;
        logic [31:0] media;
        logic        last;
    } t_feedback;

    // mirror of the recorder: registers, window state and the feedback still owed
    class feedback_tracker;
        logic [31:0] window_time;
        logic [6:0]  backlog;
        logic [30:0] epoch_limit;
        logic [31:0] sender_ssrc;
        logic [31:0] media_ssrc;
        bit          epoch_valid;
        logic [47:0] epoch_base;
        logic [15:0] win_base;
        logic [47:0] win_start;
        logic [47:0] arrival [SPAN];
        bit [SPAN-1:0] present;
        int          count;
        int          high_off;
        t_feedback   due[$];
        int          mismatches;

        function new();
            window_time = WINDOW_TIME_RST;
            backlog     = BACKLOG_RST;
            epoch_limit = EPOCH_LIMIT_RST;
            sender_ssrc = '0;
            media_ssrc  = '0;
            epoch_valid = 1'b0;
            epoch_base  = '0;
            win_base    = '0;
            win_start   = '0;
            present     = '0;
            count       = 0;
            high_off    = 0;
            mismatches  = 0;
            foreach (arrival[i]) arrival[i] = '0;
        endfunction

        // exact difference of two 48-bit times
        static function longint span48(logic [47:0] a, logic [47:0] b);
            return longint'({16'd0, a}) - longint'({16'd0, b});
        endfunction

        static function logic [31:0] clamp_s32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return 32'(v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_WINDOW_TIME: window_time = data;
                CFG_BACKLOG:     backlog = data[6:0];
                CFG_EPOCH_LIMIT: epoch_limit = data[30:0];
                CFG_SENDER_SSRC: sender_ssrc = data;
                CFG_MEDIA_SSRC:  media_ssrc = data;
                default: ;
            endcase
        endfunction

        function void owe(logic [1:0] kind, logic [15:0] pseq, logic [30:0] reft,
                          logic [31:0] rel, logic last);
            t_feedback fb;
            fb.kind        = kind;
            fb.packet_seq  = pseq;
            fb.base_seq    = (kind == KIND_NONE) ? 16'd0 : win_base;
            fb.ref_time    = reft;
            fb.rel_arrival = rel;
            fb.sender      = (kind == KIND_NONE) ? 32'd0 : sender_ssrc;
            fb.media       = (kind == KIND_NONE) ? 32'd0 : media_ssrc;
            fb.last        = last;
            due = {due, fb};
        endfunction

        // advance the mirror by one accepted command and queue its feedback
        function void note_command(logic op, logic [15:0] seq, logic [47:0] t);
            logic [15:0] delta;
            logic [47:0] first;
            longint      r;
            int          off;
            int          n;
            if (op == OP_ARRIVAL) begin
                if (!epoch_valid) begin
                    epoch_base  = t;
                    epoch_valid = 1'b1;
                end
                if (count == 0) begin
                    win_base  = seq;
                    win_start = t;
                end
                delta = seq - win_base;
                off   = int'(delta);
                if (off >= SPAN) return;
                if (!present[off]) begin
                    present[off] = 1'b1;
                    count++;
                    if (off > high_off || count == 1) high_off = off;
                end
                arrival[off] = t;
                return;
            end
            // build request
            if (count == 0 || (span48(t, win_start) < longint'({32'd0, window_time})
                               && count < int'(backlog))) begin
                owe(KIND_NONE, 16'd0, 31'd0, 32'd0, 1'b1);
                return;
            end
            first = arrival[0];
            if (span48(first, epoch_base) > longint'({33'd0, epoch_limit})) epoch_base = first;
            r = span48(first, epoch_base);
            if (r < 0) r = 0;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            n = high_off + 1;
            for (int i = 0; i < n; i++) begin
                if (present[i])
                    owe(KIND_RECEIVED, win_base + 16'(i), 31'(r),
                        clamp_s32(span48(arrival[i], epoch_base)), i == n - 1);
                else
                    owe(KIND_LOST, win_base + 16'(i), 31'(r), 32'd0, i == n - 1);
            end
            present  = '0;
            count    = 0;
            high_off = 0;
        endfunction

        task report(string msg);
            if (mismatches < PRINT_MAX) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(t_feedback got);
            t_feedback exp;
            string     bad;
            if (due.size() == 0) begin
                report($sformatf("unexpected feedback kind %0d seq %h", got.kind, got.packet_seq));
                return;
            end
            exp = due.pop_front();
            bad = "";
            if (got.kind !== exp.kind)
                bad = {bad, $sformatf(" kind %0d exp %0d", got.kind, exp.kind)};
            if (got.packet_seq !== exp.packet_seq)
                bad = {bad, $sformatf(" packet_seq %h exp %h", got.packet_seq, exp.packet_seq)};
            if (got.base_seq !== exp.base_seq)
                bad = {bad, $sformatf(" base_seq %h exp %h", got.base_seq, exp.base_seq)};
            if (got.ref_time !== exp.ref_time)
                bad = {bad, $sformatf(" ref_time %0d exp %0d", got.ref_time, exp.ref_time)};
            if (got.rel_arrival !== exp.rel_arrival)
                bad = {bad, $sformatf(" rel %0d exp %0d", $signed(got.rel_arrival),
                                      $signed(exp.rel_arrival))};
            if (got.sender !== exp.sender)
                bad = {bad, $sformatf(" sender %h exp %h", got.sender, exp.sender)};
            if (got.media !== exp.media)
                bad = {bad, $sformatf(" media %h exp %h", got.media, exp.media)};
            if (got.last !== exp.last)
                bad = {bad, $sformatf(" last %b exp %b", got.last, exp.last)};
            if (bad != "") report($sformatf("seq %h:%s", exp.packet_seq, bad));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_operation;
    logic [SEQ_W-1:0]     i_seq;
    logic [TIME_W-1:0]    i_time_us;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                 o_valid;
    logic [1:0]           o_kind;
    logic [SEQ_W-1:0]     o_packet_seq;
    logic [SEQ_W-1:0]     o_base_seq;
    logic [30:0]          o_ref_time_us;
    logic signed [31:0]   o_rel_arrival_us;
    logic [31:0]          o_out_sender_ssrc;
    logic [31:0]          o_out_media_ssrc;
    logic                 o_last;

    feedback_tracker sb;
    int              idle_pct;
    logic [47:0]     now;
    int              idle_plan [PHASES] = '{0, 78, 20, 0, 78, 20};

    twcc_arrival_window_recorder_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_seq             (i_seq),
        .i_time_us         (i_time_us),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_packet_seq      (o_packet_seq),
        .o_base_seq        (o_base_seq),
        .o_ref_time_us     (o_ref_time_us),
        .o_rel_arrival_us  (o_rel_arrival_us),
        .o_out_sender_ssrc (o_out_sender_ssrc),
        .o_out_media_ssrc  (o_out_media_ssrc),
        .o_last            (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // every feedback transaction is live for one cycle only, so sample each edge
    always @(posedge i_clk) begin
        t_feedback got;
        if (i_rst_n && o_valid) begin
            got.kind        = o_kind;
            got.packet_seq  = o_packet_seq;
            got.base_seq    = o_base_seq;
            got.ref_time    = o_ref_time_us;
            got.rel_arrival = o_rel_arrival_us;
            got.sender      = o_out_sender_ssrc;
            got.media       = o_out_media_ssrc;
            got.last        = o_last;
            sb.check_result(got);
        end
    end

    // optional idle gap, then hold the command until the block takes it
    task automatic send_command(logic op, logic [15:0] seq, logic [47:0] t);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        start       <= 1'b1;
        i_operation <= op;
        i_seq       <= seq;
        i_time_us   <= t;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, seq, t);
    endtask

    // stop sending and wait for all owed feedback plus the tail of an arrival
    task automatic drain();
        start <= 1'b0;
        while (sb.due.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // register setup per phase, extremes included
    task automatic configure(int phase);
        case (phase)
            0: begin
                // any age of one microsecond or more is old enough
                write_reg(CFG_WINDOW_TIME, 32'd1);
                write_reg(CFG_BACKLOG, 32'd64);
                write_reg(CFG_EPOCH_LIMIT, 32'h7FFF_FFFF);
                write_reg(CFG_SENDER_SSRC, 32'hFFFF_FFFF);
                write_reg(CFG_MEDIA_SSRC, 32'd0);
            end
            1: begin
                // only the backlog triggers, epoch resets on nearly every build
                write_reg(CFG_WINDOW_TIME, 32'hFFFF_FFFF);
                write_reg(CFG_BACKLOG, 32'd1);
                write_reg(CFG_EPOCH_LIMIT, 32'd1);
                write_reg(CFG_SENDER_SSRC, $urandom);
                write_reg(CFG_MEDIA_SSRC, $urandom);
                write_reg(CFG_SPARE, $urandom);
            end
            2: begin
                // zero backlog makes any open window ready
                write_reg(CFG_WINDOW_TIME, 32'd50000);
                write_reg(CFG_BACKLOG, 32'd0);
                write_reg(CFG_EPOCH_LIMIT, 32'd1000000);
                write_reg(CFG_SENDER_SSRC, 32'd0);
                write_reg(CFG_MEDIA_SSRC, 32'hFFFF_FFFF);
            end
            3: begin
                // backlog above the span, so only age can trigger
                write_reg(CFG_WINDOW_TIME, $urandom_range(1, 200000));
                write_reg(CFG_BACKLOG, 32'd127);
                write_reg(CFG_EPOCH_LIMIT, 32'd240000000);
                write_reg(CFG_SENDER_SSRC, $urandom);
                write_reg(CFG_MEDIA_SSRC, $urandom);
            end
            4: begin
                // top data bit of the epoch limit falls outside the register
                write_reg(CFG_WINDOW_TIME, 32'd30000);
                write_reg(CFG_BACKLOG, 32'd8);
                write_reg(CFG_EPOCH_LIMIT, 32'hFFFF_FFFF);
                write_reg(CFG_SENDER_SSRC, $urandom);
                write_reg(CFG_MEDIA_SSRC, $urandom);
            end
            default: begin
                write_reg(CFG_WINDOW_TIME, 32'd100000);
                write_reg(CFG_BACKLOG, 32'd64);
                write_reg(CFG_EPOCH_LIMIT, 32'd5000000);
                write_reg(CFG_SENDER_SSRC, $urandom);
                write_reg(CFG_MEDIA_SSRC, $urandom);
            end
        endcase
    endtask

    // mostly packets near the open window with rising time, some noise
    task automatic random_item();
        int          pick;
        int          off;
        logic [15:0] seq;
        logic [15:0] near;
        logic [47:0] t;
        pick = $urandom_range(0, 99);
        seq  = 16'($urandom);
        near = seq;
        if (sb.count > 0) begin
            case ($urandom_range(0, 19))
                0:          off = $urandom_range(SPAN, 300);        // past the span
                1:          off = 65536 - $urandom_range(1, 8);     // behind the base
                2, 3, 4, 5: off = $urandom_range(0, SPAN - 1);
                default:    off = $urandom_range(0, 15);
            endcase
            near = sb.win_base + 16'(off);
        end
        if (pick < 14) begin
            if ($urandom_range(0, 9) == 0) begin
                t = now - 48'($urandom_range(0, 200000));
            end else begin
                now = now + 48'($urandom_range(0, 150000));
                t   = now;
            end
            send_command(OP_BUILD, seq, t);
        end else if (pick < 86) begin
            now = now + 48'($urandom_range(0, 12000));
            send_command(OP_ARRIVAL, near, now);
        end else if (pick < 92) begin
            send_command(OP_ARRIVAL, seq, now);
        end else if (pick < 97) begin
            // reordered packet with an older timestamp
            send_command(OP_ARRIVAL, near, now - 48'($urandom_range(0, 100000)));
        end else begin
            // arbitrary 48-bit time, sometimes the clock jumps there
            t = {16'($urandom), 32'($urandom)};
            if ($urandom_range(0, 1) == 1) now = t;
            send_command(pick[0] ? OP_BUILD : OP_ARRIVAL, near, t);
        end
    endtask

    initial begin
        start       <= 1'b0;
        i_operation <= OP_ARRIVAL;
        i_seq       <= '0;
        i_time_us   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_WINDOW_TIME;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        sb          = new();
        idle_pct    = 20;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // build on an empty window
        send_command(OP_BUILD, 16'h0000, 48'd5);
        // first arrival ever sets the epoch, base at the top of the sequence space
        send_command(OP_ARRIVAL, 16'hFFFF, 48'd1000);
        send_command(OP_ARRIVAL, 16'h0000, 48'd1100);
        // duplicate overwrites the earlier time
        send_command(OP_ARRIVAL, 16'h0000, 48'd1200);
        // last slot of the span, then one past it and one behind the base
        send_command(OP_ARRIVAL, 16'h003E, 48'd1300);
        send_command(OP_ARRIVAL, 16'h003F, 48'd1400);
        send_command(OP_ARRIVAL, 16'hFFFE, 48'd1500);
        // one microsecond too young, then exactly old enough: full span of feedback
        send_command(OP_BUILD, 16'hFFFF, 48'd100999);
        send_command(OP_BUILD, 16'h5A5A, 48'd101000);
        // arrival before the epoch, then one far after it that saturates positive
        send_command(OP_ARRIVAL, 16'h8000, 48'd500);
        send_command(OP_ARRIVAL, 16'h8001, 48'h0000_8000_0405);
        // time going backwards counts as too young
        send_command(OP_BUILD, 16'h0000, 48'd400);
        send_command(OP_BUILD, 16'h0000, 48'd100500);
        // first arrival past the epoch limit moves the epoch
        send_command(OP_ARRIVAL, 16'h0100, 48'd241001001);
        send_command(OP_BUILD, 16'h0000, 48'd241101001);
        // nonzero reference time and a lost packet between two received
        send_command(OP_ARRIVAL, 16'h0200, 48'd241201001);
        send_command(OP_ARRIVAL, 16'h0202, 48'd241201100);
        send_command(OP_BUILD, 16'h0000, 48'd241301001);
        // zero time and maximum time
        send_command(OP_ARRIVAL, 16'hFFFF, 48'd0);
        send_command(OP_BUILD, 16'hFFFF, 48'd0);
        send_command(OP_BUILD, 16'hFFFF, 48'hFFFF_FFFF_FFFF);

        now = 48'd300_000_000;
        for (int phase = 0; phase < PHASES; phase++) begin
            // registers change only with the block idle and nothing owed
            drain();
            configure(phase);
            idle_pct = idle_plan[phase];
            repeat (PHASE_ITEMS) random_item();
        end
        drain();

        if (sb.due.size() != 0)
            sb.report($sformatf("%0d feedback transactions never arrived", sb.due.size()));
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
